>>> src/bisc_pkg.sv
package bisc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned DevIdW   = 3;

  localparam int unsigned IdResetDefault   = 1;
  localparam int unsigned MaxClicksDefault = 4;

  localparam logic [TimerW-1:0] DebounceReset = 16'd30;
  localparam logic [TimerW-1:0] StepReset     = 16'd200;
  localparam logic [TimerW-1:0] GapReset      = 16'd1200;
  localparam logic [TimerW-1:0] TimeoutReset  = 16'd2000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_STEP     = 2'd1,
    CFG_GAP      = 2'd2,
    CFG_TIMEOUT  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TimerW-1:0] debounce_ticks;
    logic [TimerW-1:0] blink_step_ticks;
    logic [TimerW-1:0] blink_gap_ticks;
    logic [TimerW-1:0] setting_timeout_ticks;
  } cfg_t;

  function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
    return (v == {TimerW{1'b1}}) ? v : v + TimerW'(1);
  endfunction

endpackage

>>> src/bisc_if.sv
interface bisc_in_if;
  logic valid;
  logic ready;
  logic button_pressed;
  modport source (output valid, output button_pressed, input ready);
  modport sink   (input valid, input button_pressed, output ready);
endinterface

interface bisc_out_if;
  logic       valid;
  logic       ready;
  logic       led_level;
  logic       mode;
  logic [2:0] device_id;
  logic       valid_press;
  modport source (output valid, output led_level, output mode, output device_id,
                  output valid_press, input ready);
  modport sink   (input valid, input led_level, input mode, input device_id,
                  input valid_press, output ready);
endinterface

interface bisc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/bisc_cfg_regs.sv
module bisc_cfg_regs
  import bisc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bisc_cfg_if.sink    cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_DEBOUNCE: cfg_d.debounce_ticks        = cfg_i.data;
        CFG_STEP:     cfg_d.blink_step_ticks      = cfg_i.data;
        CFG_GAP:      cfg_d.blink_gap_ticks       = cfg_i.data;
        CFG_TIMEOUT:  cfg_d.setting_timeout_ticks = cfg_i.data;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks        <= DebounceReset;
      cfg_q.blink_step_ticks      <= StepReset;
      cfg_q.blink_gap_ticks       <= GapReset;
      cfg_q.setting_timeout_ticks <= TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/bisc_step.sv
module bisc_step
  import bisc_pkg::*;
#(
  parameter int unsigned MAX_CLICKS = MaxClicksDefault,
  parameter int unsigned CLICK_W    = $clog2(MAX_CLICKS + 1)
) (
  input  cfg_t              cfg_i,
  input  logic              now_i,
  input  logic              mode_i,
  input  logic              led_i,
  input  logic [CLICK_W-1:0] id_i,
  input  logic [CLICK_W:0]  blink_cnt_i,
  input  logic [CLICK_W-1:0] click_i,
  input  logic              last_i,
  input  logic              counted_i,
  input  logic [TimerW-1:0] deb_el_i,
  input  logic              deb_arm_i,
  input  logic [TimerW-1:0] blink_el_i,
  input  logic              blink_long_i,
  input  logic [TimerW-1:0] to_el_i,
  input  logic              to_arm_i,
  output logic              mode_o,
  output logic              led_o,
  output logic [CLICK_W-1:0] id_o,
  output logic [CLICK_W:0]  blink_cnt_o,
  output logic [CLICK_W-1:0] click_o,
  output logic              last_o,
  output logic              counted_o,
  output logic [TimerW-1:0] deb_el_o,
  output logic              deb_arm_o,
  output logic [TimerW-1:0] blink_el_o,
  output logic              blink_long_o,
  output logic [TimerW-1:0] to_el_o,
  output logic              to_arm_o,
  output logic              valid_press_o
);

  localparam logic [CLICK_W-1:0] MaxClk = CLICK_W'(MAX_CLICKS);

  logic              chk_valid;
  logic              do_check;
  logic [TimerW-1:0] limit;

  always_comb begin
    mode_o       = mode_i;
    led_o        = led_i;
    id_o         = id_i;
    blink_cnt_o  = blink_cnt_i;
    click_o      = click_i;
    last_o       = last_i;
    counted_o    = counted_i;
    deb_arm_o    = deb_arm_i;
    blink_long_o = blink_long_i;
    to_arm_o     = to_arm_i;
    blink_el_o   = sat_inc(blink_el_i);
    deb_el_o     = deb_arm_i ? sat_inc(deb_el_i) : deb_el_i;
    to_el_o      = to_arm_i ? sat_inc(to_el_i) : to_el_i;
    chk_valid    = 1'b0;
    do_check     = 1'b1;
    limit        = blink_long_i ? cfg_i.blink_gap_ticks : cfg_i.blink_step_ticks;

    if (!mode_i) begin
      if (blink_el_o >= limit) begin
        blink_el_o = '0;
        if (blink_cnt_i < {id_i, 1'b0}) begin
          blink_long_o = 1'b0;
          led_o        = ~led_i;
          blink_cnt_o  = blink_cnt_i + (CLICK_W + 1)'(1);
        end else begin
          blink_long_o = 1'b1;
          blink_cnt_o  = '0;
        end
      end
    end else if (to_arm_i && to_el_o >= cfg_i.setting_timeout_ticks) begin
      do_check = 1'b0;
    end

    // debounce / press recognition
    if (do_check) begin
      if (now_i != last_i) begin
        if (now_i) begin
          deb_el_o  = '0;
          deb_arm_o = 1'b1;
        end else begin
          counted_o = 1'b0;
        end
        last_o = now_i;
      end else if (deb_arm_i && deb_el_o >= cfg_i.debounce_ticks) begin
        deb_arm_o = 1'b0;
        if (now_i) begin
          if (!counted_i) begin
            click_o   = (click_i == MaxClk) ? CLICK_W'(1) : click_i + CLICK_W'(1);
            counted_o = 1'b1;
          end
          chk_valid = 1'b1;
        end
      end
    end

    if (!mode_i) begin
      if (chk_valid) begin
        mode_o      = 1'b1;
        blink_cnt_o = '0;
        click_o     = '0;
        to_el_o     = '0;
        to_arm_o    = 1'b1;
      end
    end else if (!do_check) begin
      to_arm_o = 1'b0;
      mode_o   = 1'b0;
      led_o    = 1'b0;
      if (click_i != '0) id_o = click_i;
    end else if (chk_valid) begin
      to_el_o  = '0;
      to_arm_o = 1'b1;
      led_o    = 1'b1;
    end else begin
      led_o = 1'b0;
    end

    valid_press_o = chk_valid;
  end

endmodule

>>> src/button_id_setting_controller_unit.sv
// A result is valid in the cycle after its tick transaction is accepted.
// One tick per cycle unless output stalls; all updates in one registered pass.
// The result register lets a new tick in while the last result is being taken.
// Reset (rst_ni low, asynchronous): normal mode, LED off, ID = ID_RESET,
// all timers, counters and flags cleared, registers at their default values.
module button_id_setting_controller_unit
  import bisc_pkg::*;
#(
  parameter int unsigned ID_RESET   = IdResetDefault,
  parameter int unsigned MAX_CLICKS = MaxClicksDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bisc_in_if.sink    btn_i,
  bisc_cfg_if.sink   cfg_i,
  bisc_out_if.source res_o
);

  localparam int unsigned CLICK_W = $clog2(MAX_CLICKS + 1);

  cfg_t cfg;

  bisc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  logic               mode_q, mode_d, led_q, led_d;
  logic [CLICK_W-1:0] id_q, id_d, click_q, click_d;
  logic [CLICK_W:0]   blink_cnt_q, blink_cnt_d;
  logic               last_q, last_d, counted_q, counted_d;
  logic [TimerW-1:0]  deb_el_q, deb_el_d, blink_el_q, blink_el_d, to_el_q, to_el_d;
  logic               deb_arm_q, deb_arm_d, blink_long_q, blink_long_d;
  logic               to_arm_q, to_arm_d;
  logic               vpress_d;

  logic               out_valid_q;
  logic               led_out_q, mode_out_q, vpress_q;
  logic [DevIdW-1:0]  dev_id_q;
  logic [CLICK_W+DevIdW-1:0] id_ext;
  logic               in_fire;

  assign btn_i.ready = !out_valid_q || res_o.ready;
  assign in_fire     = btn_i.valid && btn_i.ready;

  bisc_step #(
    .MAX_CLICKS (MAX_CLICKS),
    .CLICK_W    (CLICK_W)
  ) u_step (
    .cfg_i         (cfg),
    .now_i         (btn_i.button_pressed),
    .mode_i        (mode_q),
    .led_i         (led_q),
    .id_i          (id_q),
    .blink_cnt_i   (blink_cnt_q),
    .click_i       (click_q),
    .last_i        (last_q),
    .counted_i     (counted_q),
    .deb_el_i      (deb_el_q),
    .deb_arm_i     (deb_arm_q),
    .blink_el_i    (blink_el_q),
    .blink_long_i  (blink_long_q),
    .to_el_i       (to_el_q),
    .to_arm_i      (to_arm_q),
    .mode_o        (mode_d),
    .led_o         (led_d),
    .id_o          (id_d),
    .blink_cnt_o   (blink_cnt_d),
    .click_o       (click_d),
    .last_o        (last_d),
    .counted_o     (counted_d),
    .deb_el_o      (deb_el_d),
    .deb_arm_o     (deb_arm_d),
    .blink_el_o    (blink_el_d),
    .blink_long_o  (blink_long_d),
    .to_el_o       (to_el_d),
    .to_arm_o      (to_arm_d),
    .valid_press_o (vpress_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      led_q        <= 1'b0;
      id_q         <= CLICK_W'(ID_RESET);
      blink_cnt_q  <= '0;
      click_q      <= '0;
      last_q       <= 1'b0;
      counted_q    <= 1'b0;
      deb_el_q     <= '0;
      deb_arm_q    <= 1'b0;
      blink_el_q   <= '0;
      blink_long_q <= 1'b0;
      to_el_q      <= '0;
      to_arm_q     <= 1'b0;
    end else if (in_fire) begin
      mode_q       <= mode_d;
      led_q        <= led_d;
      id_q         <= id_d;
      blink_cnt_q  <= blink_cnt_d;
      click_q      <= click_d;
      last_q       <= last_d;
      counted_q    <= counted_d;
      deb_el_q     <= deb_el_d;
      deb_arm_q    <= deb_arm_d;
      blink_el_q   <= blink_el_d;
      blink_long_q <= blink_long_d;
      to_el_q      <= to_el_d;
      to_arm_q     <= to_arm_d;
    end
  end

  assign id_ext = {{DevIdW{1'b0}}, id_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      led_out_q  <= led_d;
      mode_out_q <= mode_d;
      dev_id_q   <= id_ext[DevIdW-1:0];
      vpress_q   <= vpress_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.led_level   = led_out_q;
  assign res_o.mode        = mode_out_q;
  assign res_o.device_id   = dev_id_q;
  assign res_o.valid_press = vpress_q;

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted tick produced no result");

  a_enter_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !mode_q && mode_d) |=> vpress_q)
    else $error("setting mode entered without a valid press");

  a_leave_led_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q && !mode_d) |=> (!led_q && !vpress_q))
    else $error("LED lit or press flagged on leaving setting mode");

  a_click_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    click_q <= CLICK_W'(MAX_CLICKS))
    else $error("press count out of range");

endmodule

>>> sim/button_id_setting_controller_unit_tb.sv
`timescale 1ns / 1ps

module button_id_setting_controller_unit_tb
  import bisc_pkg::*;
();

  localparam bit MODE_NORMAL  = 1'b0;
  localparam bit MODE_SETTING = 1'b1;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_LEN    = 200;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic              led;
    logic              mode;
    logic [DevIdW-1:0] id;
    logic              press;
  } status_t;

  typedef struct {
    bit              mode;
    bit              led;
    bit [DevIdW-1:0] id;
    bit [3:0]        blinks;
    bit [2:0]        clicks;
    bit              last;
    bit              counted;
    bit [TimerW-1:0] deb_t;
    bit              deb_on;
    bit [TimerW-1:0] blk_t;
    bit              blk_long;
    bit [TimerW-1:0] to_t;
    bit              to_on;
  } ctl_state_t;

  logic clk = 1'b0;
  logic rst_n;

  bisc_in_if  btn_if ();
  bisc_cfg_if cfg_if ();
  bisc_out_if res_if ();

  button_id_setting_controller_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .btn_i  (btn_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  ctl_state_t  ctl;
  cfg_t        ctl_cfg;
  status_t     status_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ticks_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned hold_cnt       = 0;
  bit          hold_off       = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function bit [TimerW-1:0] sat16(input bit [TimerW-1:0] v);
    return (v == {TimerW{1'b1}}) ? v : v + 1'b1;
  endfunction

  task reset_state();
    ctl_cfg = '{DebounceReset, StepReset, GapReset, TimeoutReset};
    ctl = '{default: '0};
    ctl.mode = MODE_NORMAL;
    ctl.id = DevIdW'(IdResetDefault);
  endtask

  // debounced press detection; true on the tick a held press is recognised
  function bit take_press(input bit now);
    if (now != ctl.last) begin
      if (now) begin
        ctl.deb_t = '0;
        ctl.deb_on = 1'b1;
      end else begin
        ctl.counted = 1'b0;
      end
      ctl.last = now;
      return 1'b0;
    end
    if (ctl.deb_on && ctl.deb_t >= ctl_cfg.debounce_ticks) begin
      ctl.deb_on = 1'b0;
      if (now) begin
        if (!ctl.counted) begin
          ctl.clicks = 3'(ctl.clicks % MaxClicksDefault + 1);
          ctl.counted = 1'b1;
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task next_status(input bit now, output status_t s);
    bit              press;
    bit [TimerW-1:0] limit;
    press = 1'b0;
    ctl.blk_t = sat16(ctl.blk_t);
    if (ctl.deb_on) ctl.deb_t = sat16(ctl.deb_t);
    if (ctl.to_on) ctl.to_t = sat16(ctl.to_t);
    if (ctl.mode == MODE_NORMAL) begin
      limit = ctl.blk_long ? ctl_cfg.blink_gap_ticks : ctl_cfg.blink_step_ticks;
      if (ctl.blk_t >= limit) begin
        ctl.blk_t = '0;
        if (ctl.blinks < 2 * ctl.id) begin
          ctl.blk_long = 1'b0;
          ctl.led = ~ctl.led;
          ctl.blinks = ctl.blinks + 1'b1;
        end else begin
          ctl.blk_long = 1'b1;
          ctl.blinks = '0;
        end
      end
      press = take_press(now);
      if (press) begin
        ctl.mode = MODE_SETTING;
        ctl.blinks = '0;
        ctl.clicks = '0;
        ctl.to_t = '0;
        ctl.to_on = 1'b1;
      end
    end else begin
      if (ctl.to_on && ctl.to_t >= ctl_cfg.setting_timeout_ticks) begin
        // timeout: button not examined this tick
        ctl.to_on = 1'b0;
        ctl.mode = MODE_NORMAL;
        if (ctl.clicks != 0) ctl.id = ctl.clicks;
        ctl.led = 1'b0;
      end else begin
        press = take_press(now);
        if (press) begin
          ctl.to_t = '0;
          ctl.to_on = 1'b1;
          ctl.led = 1'b1;
        end else begin
          ctl.led = 1'b0;
        end
      end
    end
    s = '{ctl.led, ctl.mode, ctl.id, press};
  endtask

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------
  task note_mismatch(input string what, input int unsigned want, input int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("mismatch %s: expected %0d, got %0d (result %0d)", what, want, got,
               results_seen);
  endtask

  always @(posedge clk) begin
    status_t want;
    status_t got;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (status_q.size() == 0) begin
          note_mismatch("result with none pending", 0, 1);
        end else begin
          want = status_q.pop_front();
          if (res_if.led_level !== want.led)
            note_mismatch("led_level", want.led, res_if.led_level);
          if (res_if.mode !== want.mode)
            note_mismatch("mode", want.mode, res_if.mode);
          if (res_if.device_id !== want.id)
            note_mismatch("device_id", want.id, res_if.device_id);
          if (res_if.valid_press !== want.press)
            note_mismatch("valid_press", want.press, res_if.valid_press);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_e'(cfg_if.index))
          CFG_DEBOUNCE: ctl_cfg.debounce_ticks        = cfg_if.data;
          CFG_STEP:     ctl_cfg.blink_step_ticks      = cfg_if.data;
          CFG_GAP:      ctl_cfg.blink_gap_ticks       = cfg_if.data;
          CFG_TIMEOUT:  ctl_cfg.setting_timeout_ticks = cfg_if.data;
          default: ;
        endcase
      end
      if (btn_if.valid && btn_if.ready) begin
        next_status(btn_if.button_pressed, got);
        status_q.push_back(got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver, long hold-off and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (hold_off) begin
      if (hold_cnt == HOLD_LEN - 1) begin
        hold_cnt <= 0;
        hold_off <= 1'b0;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL button_id_setting_controller_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_tick(input bit level);
    while ($urandom_range(99) < send_idle_pct) begin
      btn_if.valid <= 1'b0;
      @(posedge clk);
    end
    btn_if.valid <= 1'b1;
    btn_if.button_pressed <= level;
    do begin
      @(posedge clk);
    end while (!btn_if.ready);
    ticks_sent++;
  endtask

  task automatic send_level(input bit level, input int unsigned n);
    repeat (n) send_tick(level);
  endtask

  // one press and release; a clean press outlasts the debounce time
  task automatic press_once(input bit clean);
    int unsigned deb;
    deb = ctl_cfg.debounce_ticks;
    if (clean) send_level(1'b1, deb + 1 + $urandom_range(0, 3));
    else send_level(1'b1, $urandom_range(1, (deb == 0) ? 1 : deb));
    send_level(1'b0, $urandom_range(1, 3));
  endtask

  task automatic wait_idle();
    btn_if.valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] deb, input logic [15:0] step,
                            input logic [15:0] gap, input logic [15:0] tmo);
    cfg_reg_e    order[4] = '{CFG_DEBOUNCE, CFG_STEP, CFG_GAP, CFG_TIMEOUT};
    logic [15:0] vals[4];
    vals = '{deb, step, gap, tmo};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= order[i];
      cfg_if.data  <= vals[i];
      do begin
        @(posedge clk);
      end while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_level(1'b1, 2);
    send_tick(1'b0);
  endtask

  // zero registers: timers expire at once, setting mode is left on the next tick
  task automatic test_zero_registers();
    set_config('0, '0, '0, '0);
    send_level(1'b1, 2);
    send_tick(1'b0);
    send_level(1'b1, 2);
    send_tick(1'b0);
  endtask

  task automatic test_full_registers();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // enter setting, two counted presses, timeout sets ID 2
  task automatic test_id_setting();
    set_config(16'd1, 16'd1, 16'd2, 16'd4);
    repeat (3) begin
      send_level(1'b1, 2);
      send_tick(1'b0);
    end
    send_level(1'b0, 4);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_ticks, input logic [15:0] deb,
                                     input logic [15:0] step, input logic [15:0] gap,
                                     input logic [15:0] tmo);
    int unsigned stop;
    int unsigned pick;
    set_config(deb, step, gap, tmo);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop = ticks_sent + n_ticks;
    while (ticks_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        press_once(pick < 58);
      end else if (pick < 85) begin
        send_level(1'b0, ctl_cfg.setting_timeout_ticks + $urandom_range(1, 12));
      end else begin
        repeat ($urandom_range(1, 5)) send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  // receiver holds off while presses keep coming; input must stall
  task automatic test_backpressure();
    set_config(16'd2, 16'd1, 16'd4, 16'd20);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off <= 1'b1;
    repeat (6) press_once(1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    btn_if.valid = 1'b0;
    btn_if.button_pressed = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_DEBOUNCE;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
    reset_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_registers();
    test_full_registers();
    test_id_setting();
    test_random_traffic(0, 0, 450, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
                        16'($urandom_range(0, 12)), 16'($urandom_range(10, 40)));
    test_random_traffic(67, 0, 450, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
                        16'($urandom_range(0, 12)), 16'($urandom_range(10, 40)));
    test_random_traffic(0, 67, 450, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
                        16'($urandom_range(0, 12)), 16'($urandom_range(10, 40)));
    test_random_traffic(15, 15, 400, 16'd0, 16'd0, 16'hFFFF, 16'd1);
    test_backpressure();

    wait_idle();
    repeat (8) @(posedge clk);
    if (status_q.size() != 0) note_mismatch("results never delivered", 0, status_q.size());
    if (mismatch_cnt == 0) begin
      $display("PASS button_id_setting_controller_unit");
    end else begin
      $display("FAIL button_id_setting_controller_unit");
    end
    $finish;
  end

endmodule
